/* src/vdc_pkg.sv */
// shared constants, codes and types of the valid 2d convolution unit
`timescale 1ns / 1ps
package vdc_pkg;
   localparam int DEF_MAX_IMAGE_WIDTH  = 64;
   localparam int DEF_MAX_IMAGE_HEIGHT = 64;
   localparam int DEF_MAX_KERNEL_HEIGHT = 8;
   localparam int DEF_MAX_KERNEL_WIDTH  = 8;

   localparam int SAMPLE_W   = 16;
   localparam int RESULT_W   = 32;
   localparam int POS_W      = 6;
   localparam int IMG_REG_W  = 7;
   localparam int KER_REG_W  = 4;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 2'd3;

   localparam logic OP_KERNEL = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // sized for the largest parameter range
   localparam int SLOT_W = 4;
   localparam int COL_W  = 10;
   localparam int KDIM_W = 5;

   typedef struct packed {
      logic              err;
      logic              last;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [SLOT_W-1:0] slot0;
      logic [COL_W-1:0]  col0;
      logic [KDIM_W-1:0] kh;
      logic [KDIM_W-1:0] kw;
   } vdc_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } vdc_stat_type;
endpackage

/* src/vdc_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module vdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* src/vdc_mac.sv */
// window sequencer and shared multiply-accumulate unit
`timescale 1ns / 1ps
module vdc_mac #(
   parameter int MAX_IMAGE_WIDTH   = vdc_pkg::DEF_MAX_IMAGE_WIDTH,
   parameter int MAX_KERNEL_HEIGHT = vdc_pkg::DEF_MAX_KERNEL_HEIGHT,
   parameter int MAX_KERNEL_WIDTH  = vdc_pkg::DEF_MAX_KERNEL_WIDTH,
   localparam int LS_DEPTH = MAX_KERNEL_HEIGHT * MAX_IMAGE_WIDTH,
   localparam int KS_DEPTH = MAX_KERNEL_HEIGHT * MAX_KERNEL_WIDTH,
   localparam int LA_W = LS_DEPTH > 1 ? $clog2(LS_DEPTH) : 1,
   localparam int KA_W = KS_DEPTH > 1 ? $clog2(KS_DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  vdc_pkg::vdc_cmd_type               cmd,
   output logic [LA_W-1:0]                    line_addr,
   output logic [KA_W-1:0]                    kern_addr,
   input  logic [vdc_pkg::SAMPLE_W-1:0]       line_data,
   input  logic [vdc_pkg::SAMPLE_W-1:0]       kern_data,
   output vdc_pkg::vdc_stat_type              stat,
   input  logic                               done_ready,
   output vdc_pkg::vdc_cmd_type               res_cmd,
   output logic [vdc_pkg::RESULT_W-1:0]       res_value
);
   localparam int ACC_W = vdc_pkg::RESULT_W + $clog2(KS_DEPTH + 1) + 1;

   vdc_pkg::vdc_cmd_type cmd_ff;
   logic issue_ff, rd_v_ff, rd_last_ff, prod_v_ff, prod_last_ff, done_ff;
   logic [vdc_pkg::KDIM_W-1:0] i_ff, j_ff;
   logic [vdc_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic signed [vdc_pkg::RESULT_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic last_col, last_tap, sat_hi, sat_lo;

   assign last_col = j_ff == cmd_ff.kw - 1'b1;
   assign last_tap = last_col && (i_ff == cmd_ff.kh - 1'b1);
   assign slot_in  = (slot_ff == vdc_pkg::SLOT_W'(MAX_KERNEL_HEIGHT - 1)) ? '0 : slot_ff + 1'b1;

   assign line_addr = LA_W'(int'(slot_ff) * MAX_IMAGE_WIDTH + int'(cmd_ff.col0) + int'(j_ff));
   assign kern_addr = KA_W'(int'(i_ff) * MAX_KERNEL_WIDTH + int'(j_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         rd_v_ff      <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_v_ff    <= 1'b0;
         prod_last_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rd_v_ff      <= issue_ff;
         rd_last_ff   <= issue_ff && last_tap;
         prod_v_ff    <= rd_v_ff;
         prod_last_ff <= rd_last_ff;
         if (start) begin
            issue_ff <= !cmd.err;
            done_ff  <= cmd.err;
         end else begin
            if (issue_ff && last_tap) begin
               issue_ff <= 1'b0;
            end
            if (prod_v_ff && prod_last_ff) begin
               done_ff <= 1'b1;
            end else if (done_ff && done_ready) begin
               done_ff <= 1'b0;
            end
         end
      end
   end

   // tap walk and datapath
   always_ff @(posedge clock) begin
      prod_ff <= $signed(line_data) * $signed(kern_data);
      if (start) begin
         cmd_ff  <= cmd;
         i_ff    <= '0;
         j_ff    <= '0;
         slot_ff <= cmd.slot0;
         acc_ff  <= '0;
      end else begin
         if (issue_ff) begin
            if (last_col) begin
               j_ff    <= '0;
               i_ff    <= i_ff + 1'b1;
               slot_ff <= slot_in;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         if (prod_v_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   assign sat_hi = !acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:vdc_pkg::RESULT_W-1] != '0);
   assign sat_lo = acc_ff[ACC_W-1] && (acc_ff[ACC_W-2:vdc_pkg::RESULT_W-1] != '1);

   always_comb begin
      if (sat_hi) begin
         res_value = {1'b0, {(vdc_pkg::RESULT_W-1){1'b1}}};
      end else if (sat_lo) begin
         res_value = {1'b1, {(vdc_pkg::RESULT_W-1){1'b0}}};
      end else begin
         res_value = acc_ff[vdc_pkg::RESULT_W-1:0];
      end
   end

   assign res_cmd   = cmd_ff;
   assign stat.busy = issue_ff || rd_v_ff || prod_v_ff || done_ff;
   assign stat.done = done_ff;

   a_no_issue_when_done: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && issue_ff)) else $error("issue while result pending");
   a_err_no_taps: assert property (@(posedge clock) disable iff (reset)
      (start && cmd.err) |=> (!issue_ff && done_ff)) else $error("error result walked taps");
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (issue_ff && last_tap && !start) |=> ##2 done_ff) else $error("window did not finish");
endmodule

/* src/valid_2d_convolution_unit.sv */
// top level of the streaming valid-mode 2d cross-correlation unit
`timescale 1ns / 1ps
// Kernel words (operation 0) and then image samples (operation 1) arrive
// row-major as signed Q8.8. Each sample is written into a ring of line
// buffers in one ram, kernel words into a second ram. A sample that
// completes a window starts the tap walk: one shared multiplier reads one
// kernel word and one buffered sample per cycle; the products pass the ram
// read and product registers into the accumulator, whose saturated sum is
// loaded into the output register before the next request is taken. Kernel
// words and samples that close no window start no walk. A finished sum
// waits, and no request is taken, while the output register is still full.
// The Q16.16 sum is saturated to 32 bits and held in an output register,
// so the next request is accepted while a result waits. A kernel larger
// than the image gives a single size_error result on the last sample.
// Configuration must only be written while the unit is idle.
module valid_2d_convolution_unit #(
   parameter int MAX_IMAGE_WIDTH   = vdc_pkg::DEF_MAX_IMAGE_WIDTH,
   parameter int MAX_IMAGE_HEIGHT  = vdc_pkg::DEF_MAX_IMAGE_HEIGHT,
   parameter int MAX_KERNEL_HEIGHT = vdc_pkg::DEF_MAX_KERNEL_HEIGHT,
   parameter int MAX_KERNEL_WIDTH  = vdc_pkg::DEF_MAX_KERNEL_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic signed [vdc_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [vdc_pkg::RESULT_W-1:0] rsp_result_value,
   output logic [vdc_pkg::POS_W-1:0]         rsp_out_row,
   output logic [vdc_pkg::POS_W-1:0]         rsp_out_col,
   output logic                              rsp_last,
   output logic                              rsp_size_error,
   input  logic                              csr_write_enable,
   input  logic [vdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [vdc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   localparam int LS_DEPTH = MAX_KERNEL_HEIGHT * MAX_IMAGE_WIDTH;
   localparam int KS_DEPTH = MAX_KERNEL_HEIGHT * MAX_KERNEL_WIDTH;
   localparam int LA_W   = LS_DEPTH > 1 ? $clog2(LS_DEPTH) : 1;
   localparam int KA_W   = KS_DEPTH > 1 ? $clog2(KS_DEPTH) : 1;
   localparam int ROW_W  = MAX_IMAGE_HEIGHT > 1 ? $clog2(MAX_IMAGE_HEIGHT) : 1;
   localparam int CCOL_W = MAX_IMAGE_WIDTH > 1 ? $clog2(MAX_IMAGE_WIDTH) : 1;
   localparam int RING_W = MAX_KERNEL_HEIGHT > 1 ? $clog2(MAX_KERNEL_HEIGHT) : 1;
   localparam int KIDX_W = $clog2(KS_DEPTH + 1);

   // configuration registers
   logic [vdc_pkg::IMG_REG_W-1:0] ih_ff, iw_ff;
   logic [vdc_pkg::KER_REG_W-1:0] kh_ff, kw_ff;

   // stream position
   logic [ROW_W-1:0]  row_ff;
   logic [CCOL_W-1:0] col_ff;
   logic [RING_W-1:0] ring_ff;
   logic [KIDX_W-1:0] kidx_ff;

   // output register
   logic rsp_valid_ff, rsp_last_ff, rsp_err_ff;
   logic [vdc_pkg::RESULT_W-1:0] rsp_value_ff;
   logic [vdc_pkg::POS_W-1:0] rsp_row_ff, rsp_col_ff;

   int ih, iw, kh, kw, r, c, ki, kj;
   logic size_err, frame_end, window, acc_img, acc_ker, kern_wr, start, load;
   vdc_pkg::vdc_cmd_type cmd, res_cmd;
   vdc_pkg::vdc_stat_type mac_stat;
   logic [LA_W-1:0] line_wr_addr, line_rd_addr;
   logic [KA_W-1:0] kern_wr_addr, kern_rd_addr;
   logic [vdc_pkg::SAMPLE_W-1:0] line_rd_data, kern_rd_data;
   logic [vdc_pkg::RESULT_W-1:0] res_value;

   function automatic int clampv(input int v, input int hi);
      int res;
      res = v;
      if (v < 1) res = 1;
      if (v > hi) res = hi;
      return res;
   endfunction

   // clamped sizes and the position of this sample
   always_comb begin
      ih = clampv(int'(ih_ff), MAX_IMAGE_HEIGHT);
      iw = clampv(int'(iw_ff), MAX_IMAGE_WIDTH);
      kh = clampv(int'(kh_ff), MAX_KERNEL_HEIGHT);
      kw = clampv(int'(kw_ff), MAX_KERNEL_WIDTH);
      r  = (int'(row_ff) >= ih) ? ih - 1 : int'(row_ff);
      c  = (int'(col_ff) >= iw) ? iw - 1 : int'(col_ff);
      size_err  = (kh > ih) || (kw > iw);
      frame_end = (r == ih - 1) && (c == iw - 1);
      window    = !size_err && (r + 1 >= kh) && (c + 1 >= kw);
   end

   assign req_ready = !mac_stat.busy;
   assign acc_img   = req_valid && req_ready && (req_operation == vdc_pkg::OP_SAMPLE);
   assign acc_ker   = req_valid && req_ready && (req_operation == vdc_pkg::OP_KERNEL);
   assign start     = acc_img && (window || (size_err && frame_end));

   // split the kernel word count into row and column, one compare per row
   always_comb begin
      ki = 0;
      for (int t = 1; t < MAX_KERNEL_HEIGHT; t++) begin
         if (int'(kidx_ff) >= t * kw) ki = ki + 1;
      end
      kj = int'(kidx_ff) - ki * kw;
   end

   assign kern_wr      = acc_ker && (int'(kidx_ff) < kh * kw);
   assign kern_wr_addr = KA_W'(ki * MAX_KERNEL_WIDTH + kj);
   assign line_wr_addr = LA_W'(int'(ring_ff) * MAX_IMAGE_WIDTH + c);

   // window command for the tap walk
   always_comb begin
      cmd.err   = size_err;
      cmd.last  = frame_end;
      cmd.row   = size_err ? '0 : vdc_pkg::POS_W'(r - (kh - 1));
      cmd.col   = size_err ? '0 : vdc_pkg::POS_W'(c - (kw - 1));
      cmd.slot0 = (int'(ring_ff) >= kh - 1) ? vdc_pkg::SLOT_W'(int'(ring_ff) - (kh - 1))
                : vdc_pkg::SLOT_W'(int'(ring_ff) + MAX_KERNEL_HEIGHT - (kh - 1));
      cmd.col0  = vdc_pkg::COL_W'(c - (kw - 1));
      cmd.kh    = vdc_pkg::KDIM_W'(kh);
      cmd.kw    = vdc_pkg::KDIM_W'(kw);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ih_ff <= vdc_pkg::IMG_REG_W'(8);
         iw_ff <= vdc_pkg::IMG_REG_W'(8);
         kh_ff <= vdc_pkg::KER_REG_W'(3);
         kw_ff <= vdc_pkg::KER_REG_W'(3);
      end else if (csr_write_enable) begin
         case (csr_index)
            vdc_pkg::CSR_IMAGE_HEIGHT:  ih_ff <= csr_write_data;
            vdc_pkg::CSR_IMAGE_WIDTH:   iw_ff <= csr_write_data;
            vdc_pkg::CSR_KERNEL_HEIGHT: kh_ff <= csr_write_data[vdc_pkg::KER_REG_W-1:0];
            vdc_pkg::CSR_KERNEL_WIDTH:  kw_ff <= csr_write_data[vdc_pkg::KER_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // stream counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         ring_ff <= '0;
         kidx_ff <= '0;
      end else begin
         if (kern_wr) begin
            kidx_ff <= kidx_ff + 1'b1;
         end
         if (acc_img) begin
            if (frame_end) begin
               row_ff  <= '0;
               col_ff  <= '0;
               ring_ff <= '0;
               kidx_ff <= '0;
            end else if (c + 1 >= iw) begin
               col_ff  <= '0;
               row_ff  <= ROW_W'(r + 1);
               ring_ff <= (int'(ring_ff) == MAX_KERNEL_HEIGHT - 1) ? '0 : ring_ff + 1'b1;
            end else begin
               row_ff <= ROW_W'(r);
               col_ff <= CCOL_W'(c + 1);
            end
         end
      end
   end

   vdc_ram #(.WIDTH(vdc_pkg::SAMPLE_W), .DEPTH(LS_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (acc_img),
      .wr_addr (line_wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   vdc_ram #(.WIDTH(vdc_pkg::SAMPLE_W), .DEPTH(KS_DEPTH)) u_kern_ram (
      .clock   (clock),
      .wr_en   (kern_wr),
      .wr_addr (kern_wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (kern_rd_addr),
      .rd_data (kern_rd_data)
   );

   vdc_mac #(
      .MAX_IMAGE_WIDTH   (MAX_IMAGE_WIDTH),
      .MAX_KERNEL_HEIGHT (MAX_KERNEL_HEIGHT),
      .MAX_KERNEL_WIDTH  (MAX_KERNEL_WIDTH)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (cmd),
      .line_addr  (line_rd_addr),
      .kern_addr  (kern_rd_addr),
      .line_data  (line_rd_data),
      .kern_data  (kern_rd_data),
      .stat       (mac_stat),
      .done_ready (load),
      .res_cmd    (res_cmd),
      .res_value  (res_value)
   );

   // output register, refilled as soon as the slot frees
   assign load = mac_stat.done && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_value_ff <= res_cmd.err ? '0 : res_value;
         rsp_row_ff   <= res_cmd.row;
         rsp_col_ff   <= res_cmd.col;
         rsp_last_ff  <= res_cmd.last;
         rsp_err_ff   <= res_cmd.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_out_row      = rsp_row_ff;
   assign rsp_out_col      = rsp_col_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_size_error   = rsp_err_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> mac_stat.busy) else $error("window start lost");
   a_kernel_no_work: assert property (@(posedge clock) disable iff (reset)
      acc_ker |=> !mac_stat.busy) else $error("kernel word started work");
   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_value_ff == '0 && rsp_last_ff))
      else $error("bad size error result");
endmodule

/* sim/tb_valid_2d_convolution_unit.sv */
// self-checking testbench of the valid 2d convolution unit
`timescale 1ns / 1ps
module tb_valid_2d_convolution_unit;
   localparam int MAX_IH = vdc_pkg::DEF_MAX_IMAGE_HEIGHT;
   localparam int MAX_IW = vdc_pkg::DEF_MAX_IMAGE_WIDTH;
   localparam int MAX_KH = vdc_pkg::DEF_MAX_KERNEL_HEIGHT;
   localparam int MAX_KW = vdc_pkg::DEF_MAX_KERNEL_WIDTH;
   localparam int KSTORE = MAX_KH * MAX_KW;
   localparam int LSTORE = MAX_KH * MAX_IW;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 6000;
   localparam int ITEM_TARGET   = 1600;

   typedef struct {
      logic signed [vdc_pkg::RESULT_W-1:0] value;
      logic [vdc_pkg::POS_W-1:0]           row;
      logic [vdc_pkg::POS_W-1:0]           col;
      logic                                last;
      logic                                err;
   } window_sum_type;

   // window sum predictor and queue of expected sums
   class conv_scoreboard;
      logic [vdc_pkg::IMG_REG_W-1:0]       rows_reg = 8, cols_reg = 8;
      logic [vdc_pkg::KER_REG_W-1:0]       krows_reg = 3, kcols_reg = 3;
      logic signed [vdc_pkg::SAMPLE_W-1:0] coeffs[KSTORE];
      logic signed [vdc_pkg::SAMPLE_W-1:0] lines[LSTORE];
      int                                  coeff_idx, pix_row, pix_col, ring;
      window_sum_type                      pending_sums[$];
      int                                  mismatches, sums_seen, errors_seen;

      function int fit(int v, int hi);
         return (v < 1) ? 1 : (v > hi) ? hi : v;
      endfunction

      function void set_reg(logic [vdc_pkg::CSR_IDX_W-1:0] idx,
                            logic [vdc_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            vdc_pkg::CSR_IMAGE_HEIGHT:  rows_reg = v;
            vdc_pkg::CSR_IMAGE_WIDTH:   cols_reg = v;
            vdc_pkg::CSR_KERNEL_HEIGHT: krows_reg = v[vdc_pkg::KER_REG_W-1:0];
            vdc_pkg::CSR_KERNEL_WIDTH:  kcols_reg = v[vdc_pkg::KER_REG_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic op, logic signed [vdc_pkg::SAMPLE_W-1:0] v);
         int ih, iw, kh, kw, r, c, slot;
         bit oversize, frame_end;
         longint acc;
         window_sum_type s;
         ih = fit(rows_reg, MAX_IH);
         iw = fit(cols_reg, MAX_IW);
         kh = fit(krows_reg, MAX_KH);
         kw = fit(kcols_reg, MAX_KW);
         oversize = (kh > ih) || (kw > iw);
         if (op == vdc_pkg::OP_KERNEL) begin
            if (coeff_idx < kh * kw) begin
               coeffs[(coeff_idx / kw) * MAX_KW + coeff_idx % kw] = v;
               coeff_idx++;
            end
            return;
         end
         if (pix_col >= iw) pix_col = iw - 1;
         if (pix_row >= ih) pix_row = ih - 1;
         r = pix_row;
         c = pix_col;
         lines[ring * MAX_IW + c] = v;
         frame_end = (r == ih - 1) && (c == iw - 1);
         if (!oversize && r + 1 >= kh && c + 1 >= kw) begin
            acc = 0;
            for (int i = 0; i < kh; i++) begin
               slot = (ring + 2 * MAX_KH - (kh - 1) + i) % MAX_KH;
               for (int j = 0; j < kw; j++)
                  acc += longint'(lines[slot * MAX_IW + c - (kw - 1) + j])
                         * longint'(coeffs[i * MAX_KW + j]);
            end
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            s.value = acc[vdc_pkg::RESULT_W-1:0];
            s.row = vdc_pkg::POS_W'(r - (kh - 1));
            s.col = vdc_pkg::POS_W'(c - (kw - 1));
            s.last = frame_end;
            s.err = 1'b0;
            pending_sums.push_back(s);
         end else if (oversize && frame_end) begin
            s.value = '0;
            s.row = '0;
            s.col = '0;
            s.last = 1'b1;
            s.err = 1'b1;
            pending_sums.push_back(s);
         end
         if (frame_end) begin
            pix_row = 0;
            pix_col = 0;
            ring = 0;
            coeff_idx = 0;
         end else if (c + 1 >= iw) begin
            pix_col = 0;
            pix_row++;
            ring = (ring + 1) % MAX_KH;
         end else begin
            pix_col++;
         end
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
         mismatches++;
      endtask

      task check_result(window_sum_type got);
         window_sum_type want;
         if (pending_sums.size() == 0) begin
            report_mismatch("unexpected result, value", got.value, 0);
            return;
         end
         want = pending_sums.pop_front();
         sums_seen++;
         if (want.err) errors_seen++;
         if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
         if (got.row !== want.row) report_mismatch("out_row", got.row, want.row);
         if (got.col !== want.col) report_mismatch("out_col", got.col, want.col);
         if (got.last !== want.last) report_mismatch("last", got.last, want.last);
         if (got.err !== want.err) report_mismatch("size_error", got.err, want.err);
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic                                req_operation;
   logic signed [vdc_pkg::SAMPLE_W-1:0] req_sample_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [vdc_pkg::RESULT_W-1:0] rsp_result_value;
   logic [vdc_pkg::POS_W-1:0]           rsp_out_row;
   logic [vdc_pkg::POS_W-1:0]           rsp_out_col;
   logic                                rsp_last;
   logic                                rsp_size_error;
   logic                                csr_write_enable;
   logic [vdc_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [vdc_pkg::CSR_DATA_W-1:0]      csr_write_data;

   conv_scoreboard sb = new();
   int requests_sent;
   int frames_run;
   int req_idle_pct;
   int rsp_idle_pct;
   int quiet_cycles = 0;
   int extreme_idx;
   bit kernel_loaded;
   int loaded_kh, loaded_kw;

   valid_2d_convolution_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_value (req_sample_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_last         (rsp_last),
      .rsp_size_error   (rsp_size_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: check what was taken at this edge, then pick the next ready
   initial begin
      window_sum_type got;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.value = rsp_result_value;
            got.row = rsp_out_row;
            got.col = rsp_out_col;
            got.last = rsp_last;
            got.err = rsp_size_error;
            sb.check_result(got);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // idling schedule follows the request count
   function void set_idling();
      if (requests_sent < 600) begin
         req_idle_pct = 38;
         rsp_idle_pct = 56;
      end else if (requests_sent < 1200) begin
         req_idle_pct = 56;
         rsp_idle_pct = 38;
      end else begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end
   endfunction

   // 0 random with extremes mixed in, 1 max, 2 min, 3 cycling extremes
   function logic signed [vdc_pkg::SAMPLE_W-1:0] pick_value(int mode);
      logic signed [vdc_pkg::SAMPLE_W-1:0] v;
      case (mode)
         1: v = 16'sh7fff;
         2: v = -16'sh8000;
         3: begin
            case (extreme_idx % 4)
               0: v = -16'sh8000;
               1: v = 16'sh7fff;
               2: v = '0;
               default: v = 16'sd1;
            endcase
            extreme_idx++;
         end
         default: begin
            case ($urandom_range(0, 9))
               0: v = 16'sh7fff;
               1: v = -16'sh8000;
               2: v = '0;
               default: v = vdc_pkg::SAMPLE_W'($urandom);
            endcase
         end
      endcase
      return v;
   endfunction

   task automatic send_request(input logic op,
                               input logic signed [vdc_pkg::SAMPLE_W-1:0] v);
      int gap;
      gap = 0;
      set_idling();
      while ($urandom_range(0, 99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sample_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, v);
      requests_sent++;
   endtask

   // hold the request side until every expected sum is back and, with settle set, the unit is quiet
   task automatic wait_drained(input bit settle);
      req_valid <= 1'b0;
      while (sb.pending_sums.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input int ih_r, iw_r, kh_r, kw_r);
      logic [vdc_pkg::CSR_DATA_W-1:0] vals[4];
      vals[0] = vdc_pkg::CSR_DATA_W'(ih_r);
      vals[1] = vdc_pkg::CSR_DATA_W'(iw_r);
      vals[2] = vdc_pkg::CSR_DATA_W'(kh_r);
      vals[3] = vdc_pkg::CSR_DATA_W'(kw_r);
      wait_drained(1'b1);
      for (int k = 0; k < 4; k++) begin
         csr_write_enable <= 1'b1;
         csr_index <= vdc_pkg::CSR_IDX_W'(k);
         csr_write_data <= vals[k];
         @(posedge clock);
         sb.set_reg(vdc_pkg::CSR_IDX_W'(k), vals[k]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // one frame; kernel style 0 whole kernel first, 1 reuse stored kernel,
   // 2 half first and the rest slipped in one per sample of the first image row, any left before the second
   task automatic run_frame(input int ih_r, iw_r, kh_r, kw_r, input bit reprogram,
                            input int kmode, smode, style, input bit hold_mid);
      int ih, iw, kh, kw, taps, sent, total;
      if (reprogram) write_regs(ih_r, iw_r, kh_r, kw_r);
      ih = sb.fit(sb.rows_reg, MAX_IH);
      iw = sb.fit(sb.cols_reg, MAX_IW);
      kh = sb.fit(sb.krows_reg, MAX_KH);
      kw = sb.fit(sb.kcols_reg, MAX_KW);
      taps = kh * kw;
      total = ih * iw;
      if (style == 1 && !(kernel_loaded && loaded_kh == kh && loaded_kw == kw)) style = 0;
      if (style == 2 && kh < 2) style = 0;
      sent = (style == 1) ? taps : (style == 2) ? taps / 2 : taps;
      if (style != 1)
         for (int k = 0; k < sent; k++) send_request(vdc_pkg::OP_KERNEL, pick_value(kmode));
      for (int n = 0; n < total; n++) begin
         if (n < iw && sent < taps) begin
            send_request(vdc_pkg::OP_KERNEL, pick_value(kmode));
            sent++;
         end
         while (n >= iw && sent < taps) begin
            send_request(vdc_pkg::OP_KERNEL, pick_value(kmode));
            sent++;
         end
         // stray kernel words: ignored once full, stored after a reuse
         if (sent == taps && smode == 0 && $urandom_range(0, 19) == 0)
            send_request(vdc_pkg::OP_KERNEL, pick_value(0));
         if (hold_mid && n == total / 2) wait_drained(1'b0);
         send_request(vdc_pkg::OP_SAMPLE, pick_value(smode));
      end
      kernel_loaded = 1'b1;
      loaded_kh = kh;
      loaded_kw = kw;
      frames_run++;
   endtask

   initial begin
      int ih_r, iw_r, kh_r, kw_r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = vdc_pkg::OP_KERNEL;
      req_sample_value = '0;
      csr_write_enable = 1'b0;
      csr_index = vdc_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data = '0;
      requests_sent = 0;
      set_idling();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 1x1 kernel over extremes, both saturations, kernel too big
      run_frame(2, 2, 1, 1, 1'b1, 1, 3, 0, 1'b0);
      run_frame(2, 2, 2, 2, 1'b1, 1, 1, 0, 1'b0);
      run_frame(2, 2, 2, 2, 1'b0, 2, 1, 0, 1'b0);
      run_frame(1, 2, 2, 1, 1'b1, 0, 3, 0, 1'b0);
      // register extremes: zero acts as one, oversize clamps to the maximum
      run_frame(127, 0, 15, 1, 1'b1, 0, 0, 0, 1'b0);
      run_frame(2, 127, 2, 15, 1'b1, 0, 0, 0, 1'b0);
      run_frame(0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);

      // random frames, mostly small; one waits mid-frame for all sums
      while (requests_sent < ITEM_TARGET) begin
         ih_r = $urandom_range(0, 9);
         iw_r = $urandom_range(0, 9);
         kh_r = $urandom_range(0, 4);
         kw_r = $urandom_range(0, 4);
         if ($urandom_range(0, 7) == 0) ih_r = $urandom_range(10, 20);
         if ($urandom_range(0, 5) == 0) kh_r = $urandom_range(5, 15);
         if ($urandom_range(0, 5) == 0) kw_r = $urandom_range(5, 15);
         run_frame(ih_r, iw_r, kh_r, kw_r, $urandom_range(0, 2) != 0, 0, 0,
                   $urandom_range(0, 2), frames_run == 7);
      end

      wait_drained(1'b1);
      $display("ran %0d frames with %0d requests", frames_run, requests_sent);
      $display("checked %0d window sums, %0d of them size errors",
               sb.sums_seen, sb.errors_seen);
      if (sb.mismatches == 0 && sb.pending_sums.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
